@@ rtl/core/fitch_parsimony_site_combine_macros.svh @@
// ----------------------------------------------------------------------------
// fitch_parsimony_site_combine_macros
// assertion macros used by the site combine rtl
// ----------------------------------------------------------------------------
`ifndef FITCH_PARSIMONY_SITE_COMBINE_MACROS_SVH
`define FITCH_PARSIMONY_SITE_COMBINE_MACROS_SVH

// implication checked in the same cycle
`define FPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpsc assertion failed");

// implication checked in the next cycle
`define FPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpsc assertion failed");

`endif

@@ rtl/core/fpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsc_pkg
// types and constants of the fitch parsimony site combine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpsc_pkg;

    localparam int SET_W     = 5;
    localparam int WEIGHT_W  = 16;
    localparam int COST_W    = 32;
    localparam int GAP_IDX   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP_RUNS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_MIXED_GAPS = 1'b1;

    typedef struct packed {
        logic [SET_W-1:0]    left_set;
        logic [SET_W-1:0]    right_set;
        logic [WEIGHT_W-1:0] site_weight;
        logic                first_site;
        logic                last_site;
    } fpsc_site_t;

    typedef struct packed {
        logic [SET_W-1:0]  parent_set;
        logic              mutation_counted;
        logic [COST_W-1:0] total_cost;
        logic              cost_overflow;
        logic              final_site;
    } fpsc_result_t;

    typedef struct packed {
        logic merge_gap_runs;
        logic strip_mixed_gaps;
    } fpsc_cfg_t;

    typedef struct packed {
        logic first_site;
        logic counted;
    } fpsc_site_ctl_t;

endpackage

@@ rtl/core/fpsc_interfaces.sv @@
// ----------------------------------------------------------------------------
// fpsc_interfaces
// valid/ready channels for site beats and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fpsc_site_if;
    import fpsc_pkg::*;

    logic       valid;
    logic       ready;
    fpsc_site_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fpsc_result_if;
    import fpsc_pkg::*;

    logic         valid;
    logic         ready;
    fpsc_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/fpsc_in_stage.sv @@
// ----------------------------------------------------------------------------
// fpsc_in_stage
// input register for one site beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpsc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    fpsc_site_if.sink           sites,
    input  logic                advance,
    output logic                stage_valid,
    output fpsc_pkg::fpsc_site_t stage_site
);
    import fpsc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    fpsc_site_t site_reg;
    logic       take;

    assign sites.ready = !valid_reg || advance;
    assign take        = sites.valid && sites.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            site_reg <= sites.payload;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_site  = site_reg;

endmodule

@@ rtl/core/fpsc_set_unit.sv @@
// ----------------------------------------------------------------------------
// fpsc_set_unit
// fitch set combine with gap-run merge, mixed-gap strip and gap history
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpsc_set_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  fpsc_pkg::fpsc_cfg_t         cfg,
    input  fpsc_pkg::fpsc_site_t        site,
    output logic [fpsc_pkg::SET_W-1:0]  parent_set,
    output fpsc_pkg::fpsc_site_ctl_t    ctl
);
    import fpsc_pkg::*;

    logic             prev_left_gap_reg;
    logic             prev_right_gap_reg;
    logic             prev_parent_gap_reg;
    logic [SET_W-1:0] isect;
    logic [SET_W-1:0] uni;
    logic [SET_W-1:0] raw_set;
    logic             mismatch;
    logic             left_gap;
    logic             right_gap;
    logic             gap_run;
    logic             merged;
    logic             strip;

    assign isect     = site.left_set & site.right_set;
    assign uni       = site.left_set | site.right_set;
    assign mismatch  = (isect == '0);
    assign left_gap  = site.left_set[GAP_IDX];
    assign right_gap = site.right_set[GAP_IDX];

    // a child stays in a gap, and the children were not both gapped before
    assign gap_run = ((left_gap && prev_left_gap_reg) || (right_gap && prev_right_gap_reg))
                     && !(prev_left_gap_reg && prev_right_gap_reg);

    assign merged = mismatch && cfg.merge_gap_runs && !site.first_site && uni[GAP_IDX]
                    && prev_parent_gap_reg && gap_run;

    assign raw_set = mismatch ? uni : isect;

    assign strip = !merged && cfg.strip_mixed_gaps && raw_set[GAP_IDX]
                   && (raw_set[GAP_IDX-1:0] != '0);

    always_comb
    begin
        parent_set = raw_set;
        if (strip)
        begin
            parent_set[GAP_IDX] = 1'b0;
        end
    end

    assign ctl.first_site = site.first_site;
    assign ctl.counted    = mismatch && !merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_gap_reg   <= 1'b0;
            prev_right_gap_reg  <= 1'b0;
            prev_parent_gap_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_left_gap_reg   <= left_gap;
            prev_right_gap_reg  <= right_gap;
            prev_parent_gap_reg <= parent_set[GAP_IDX];
        end
    end

endmodule

@@ rtl/core/fpsc_cost_unit.sv @@
// ----------------------------------------------------------------------------
// fpsc_cost_unit
// saturating weighted cost accumulator with overflow flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpsc_cost_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  fpsc_pkg::fpsc_site_ctl_t      ctl,
    input  logic [fpsc_pkg::WEIGHT_W-1:0] site_weight,
    output logic [fpsc_pkg::COST_W-1:0]   cost_next,
    output logic                          overflow_next
);
    import fpsc_pkg::*;

    logic [COST_W-1:0] cost_reg;
    logic              overflow_reg;
    logic [COST_W-1:0] cost_base;
    logic              overflow_base;
    logic [COST_W:0]   sum;

    // first site restarts the pair
    assign cost_base     = ctl.first_site ? '0 : cost_reg;
    assign overflow_base = ctl.first_site ? 1'b0 : overflow_reg;

    assign sum = {1'b0, cost_base} + {{(COST_W+1-WEIGHT_W){1'b0}}, site_weight};

    always_comb
    begin
        cost_next     = cost_base;
        overflow_next = overflow_base;
        if (ctl.counted)
        begin
            if (sum[COST_W])
            begin
                cost_next     = COST_MAX;
                overflow_next = 1'b1;
            end
            else
            begin
                cost_next = sum[COST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg     <= '0;
            overflow_reg <= 1'b0;
        end
        else if (advance)
        begin
            cost_reg     <= cost_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

@@ rtl/core/fitch_parsimony_site_combine.sv @@
// ----------------------------------------------------------------------------
// fitch_parsimony_site_combine
// Combines the aligned base sets of two child sequences into the Fitch parent
// set, one site per beat, and keeps a saturating weighted mutation cost that
// rides along with every result and is final on the beat marked final_site.
// A site beat is registered on entry, combined and added to the cost from that
// input register, and the result is registered on the way out, so a result
// passes the input and the output register and can stall in either while
// results are not taken; a new site is accepted every cycle while results are
// taken. The loop through the 32-bit saturating adder and the one-bit gap
// history sets that rate.
// The user must write merge_gap_runs and strip_mixed_gaps on the cfg port only
// while the block is idle, which the block does not enforce; both reset to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fitch_parsimony_site_combine_macros.svh"

module fitch_parsimony_site_combine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    fpsc_site_if.sink                       sites,
    fpsc_result_if.source                   results
);
    import fpsc_pkg::*;

    fpsc_cfg_t        cfg_reg;
    fpsc_cfg_t        cfg_next;
    logic             stage_valid;
    fpsc_site_t       stage_site;
    logic             advance;
    logic [SET_W-1:0] parent_set;
    fpsc_site_ctl_t   ctl;
    logic [COST_W-1:0] cost_next;
    logic             overflow_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    fpsc_result_t     out_reg;
    fpsc_result_t     out_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MERGE_GAP_RUNS:   cfg_next.merge_gap_runs   = cfg_wdata[0];
                CFG_STRIP_MIXED_GAPS: cfg_next.strip_mixed_gaps = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.merge_gap_runs   <= 1'b1;
            cfg_reg.strip_mixed_gaps <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance = stage_valid && (!out_valid_reg || results.ready);

    fpsc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .sites       (sites),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_site  (stage_site)
    );

    fpsc_set_unit u_set_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg_reg),
        .site       (stage_site),
        .parent_set (parent_set),
        .ctl        (ctl)
    );

    fpsc_cost_unit u_cost_unit (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .ctl           (ctl),
        .site_weight   (stage_site.site_weight),
        .cost_next     (cost_next),
        .overflow_next (overflow_next)
    );

    always_comb
    begin
        out_next.parent_set       = parent_set;
        out_next.mutation_counted = ctl.counted;
        out_next.total_cost       = cost_next;
        out_next.cost_overflow    = overflow_next;
        out_next.final_site       = stage_site.last_site;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    `FPSC_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, stage_valid && results.valid && !results.ready, !sites.ready)
    `FPSC_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, results.valid)
    `FPSC_ASSERT_IMPL(a_overflow_saturates, clk, rst_n, results.valid && results.payload.cost_overflow, results.payload.total_cost == COST_MAX)
    `FPSC_ASSERT_IMPL(a_match_not_counted, clk, rst_n, advance && ((stage_site.left_set & stage_site.right_set) != '0), !ctl.counted)

endmodule
